### hdl/tlida_pkg.sv
package tlida_pkg;

	localparam int WORD_BITS    = 32;
	localparam int GROUP_WORDS  = 2;
	localparam int MEMBER_WORDS = 2;

	localparam int ROW_BITS = 64;
	localparam int ROWS     = 64;
	localparam int IDX_W    = 6;
	localparam int CNT_W    = IDX_W + 1;

	localparam int NUM_GROUPS  = (WORD_BITS * GROUP_WORDS) < ROW_BITS ?
		(WORD_BITS * GROUP_WORDS) : ROW_BITS;
	localparam int NUM_MEMBERS = (WORD_BITS * MEMBER_WORDS) < ROW_BITS ?
		(WORD_BITS * MEMBER_WORDS) : ROW_BITS;

	typedef logic [ROW_BITS-1:0] row_t;
	typedef logic [IDX_W-1:0]    idx_t;

	typedef enum logic [2:0] {
		ACT_ALLOC_GRP = 3'd0,
		ACT_ALLOC_ID  = 3'd1,
		ACT_REL_GRP   = 3'd2,
		ACT_REL_ID    = 3'd3,
		ACT_QUERY_GRP = 3'd4,
		ACT_QUERY_ID  = 3'd5
	} act_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} st_t;

	typedef struct packed {
		logic found;
		idx_t idx;
	} hit_t;

	// index n lives at bit 63-n, which for a 6-bit index is its complement
	function automatic row_t bit_mask(input idx_t n);
		row_t m;
		m = '0;
		m[~n] = 1'b1;
		return m;
	endfunction

	// free flags by index, entries at or beyond the limit count as taken
	function automatic row_t free_vec(input row_t row, input int limit);
		row_t f;
		for (int n = 0; n < ROW_BITS; n++) begin
			f[n] = (n < limit) && !row[ROW_BITS-1-n];
		end
		return f;
	endfunction

	// lowest set index, two levels of 8-way priority
	function automatic hit_t first_set(input row_t v);
		logic [7:0] any;
		logic [7:0] sel;
		logic [2:0] hi;
		logic [2:0] lo;
		hit_t       h;
		for (int b = 0; b < 8; b++) begin
			any[b] = |v[8*b +: 8];
		end
		hi = '0;
		for (int b = 7; b >= 0; b--) begin
			if (any[b]) hi = 3'(b);
		end
		sel = v[8*hi +: 8];
		lo = '0;
		for (int i = 7; i >= 0; i--) begin
			if (sel[i]) lo = 3'(i);
		end
		h.found = |any;
		h.idx   = {hi, lo};
		return h;
	endfunction

endpackage

### hdl/tlida_ram.sv
module tlida_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

### hdl/two_level_id_bitmap_allocator_top.sv
// two-level id allocator: a group bitmap hands out group ids, and each group
// has a member bitmap in a 64-row memory that hands out member ids.
// request channel: req_valid / req_stall with action, group_id, member_id.
// response channel: rsp_valid / rsp_stall with status, granted_id, is_set.
// every request beat gives exactly one response beat, in order.
// an accepted beat is registered into the work stage, and its response is
// registered from there once the response register can take it.
// throughput: one beat per cycle while no response is stalled; the member row is
// read in the accept cycle, modified and written back as the work stage
// advances, with a bypass when the next beat addresses the row just written.
// reset: group map holds only group zero, all member rows read as zero
// through per-row valid flops, so no clearing pass is needed.
// when the receiver stalls, the response register holds, the pending beat
// waits in the work stage and req_stall goes high until the response drains.
module two_level_id_bitmap_allocator_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [2:0] action,
	input  logic [5:0] group_id,
	input  logic [5:0] member_id,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [1:0] status,
	output logic [5:0] granted_id,
	output logic       is_set
);

	logic                  accept;
	logic                  s1_adv;
	logic                  v_s1;
	logic [2:0]            action_s1;
	tlida_pkg::idx_t       gid_s1;
	tlida_pkg::idx_t       mid_s1;
	logic                  hit_s1;
	tlida_pkg::row_t       byp_row_s1;
	logic                  rowv_s1;
	tlida_pkg::row_t       rdata;

	tlida_pkg::row_t       group_map_q;
	logic [tlida_pkg::ROWS-1:0] vld_q;

	logic                  out_v_q;
	tlida_pkg::st_t        status_q;
	tlida_pkg::idx_t       granted_q;
	logic                  is_set_q;

	tlida_pkg::row_t       row;
	tlida_pkg::row_t       row_nxt;
	tlida_pkg::row_t       gm_nxt;
	logic                  row_we;
	logic                  rel_grp;
	tlida_pkg::st_t        st_nxt;
	tlida_pkg::idx_t       grant_nxt;
	logic                  set_nxt;
	tlida_pkg::hit_t       grp_hit;
	tlida_pkg::hit_t       mem_hit;
	logic                  gid_oor;
	logic                  mid_oor;
	logic                  byp_hit;

	assign s1_adv    = v_s1 && (!out_v_q || !rsp_stall);
	assign req_stall = v_s1 && !s1_adv;
	assign accept    = req_valid && !req_stall;

	tlida_ram #(
		.WIDTH(tlida_pkg::ROW_BITS),
		.DEPTH(tlida_pkg::ROWS)
	) u_rows (
		.clk  (clk),
		.we   (s1_adv && row_we),
		.waddr(gid_s1),
		.wdata(row_nxt),
		.re   (accept),
		.raddr(group_id),
		.rdata(rdata)
	);

	always_comb begin
		row     = hit_s1 ? byp_row_s1 : (rowv_s1 ? rdata : '0);
		grp_hit = tlida_pkg::first_set(tlida_pkg::free_vec(group_map_q,
			tlida_pkg::NUM_GROUPS));
		mem_hit = tlida_pkg::first_set(tlida_pkg::free_vec(row, tlida_pkg::NUM_MEMBERS));
		gid_oor = {1'b0, gid_s1} >= tlida_pkg::CNT_W'(tlida_pkg::NUM_GROUPS);
		mid_oor = {1'b0, mid_s1} >= tlida_pkg::CNT_W'(tlida_pkg::NUM_MEMBERS);

		st_nxt    = tlida_pkg::ST_OK;
		grant_nxt = '0;
		set_nxt   = 1'b0;
		gm_nxt    = group_map_q;
		row_nxt   = row;
		row_we    = 1'b0;
		rel_grp   = 1'b0;

		unique case (action_s1)
			tlida_pkg::ACT_ALLOC_GRP: begin
				if (grp_hit.found) begin
					gm_nxt    = group_map_q | tlida_pkg::bit_mask(grp_hit.idx);
					grant_nxt = grp_hit.idx;
				end else begin
					st_nxt = tlida_pkg::ST_FULL;
				end
			end
			tlida_pkg::ACT_ALLOC_ID: begin
				if (gid_oor) begin
					st_nxt = tlida_pkg::ST_RANGE;
				end else if (mem_hit.found) begin
					row_nxt   = row | tlida_pkg::bit_mask(mem_hit.idx);
					row_we    = 1'b1;
					grant_nxt = mem_hit.idx;
				end else begin
					st_nxt = tlida_pkg::ST_FULL;
				end
			end
			tlida_pkg::ACT_REL_GRP: begin
				if (gid_oor) begin
					st_nxt = tlida_pkg::ST_RANGE;
				end else begin
					gm_nxt  = group_map_q & ~tlida_pkg::bit_mask(gid_s1);
					rel_grp = 1'b1;
				end
			end
			tlida_pkg::ACT_REL_ID: begin
				if (gid_oor || mid_oor) begin
					st_nxt = tlida_pkg::ST_RANGE;
				end else begin
					row_nxt = row & ~tlida_pkg::bit_mask(mid_s1);
					row_we  = 1'b1;
				end
			end
			tlida_pkg::ACT_QUERY_GRP: begin
				if (gid_oor) st_nxt = tlida_pkg::ST_RANGE;
				else set_nxt = |(group_map_q & tlida_pkg::bit_mask(gid_s1));
			end
			tlida_pkg::ACT_QUERY_ID: begin
				if (gid_oor || mid_oor) st_nxt = tlida_pkg::ST_RANGE;
				else set_nxt = |(row & tlida_pkg::bit_mask(mid_s1));
			end
			default: begin
				st_nxt = tlida_pkg::ST_RANGE;
			end
		endcase

		// next beat reads the row that this beat writes in the same cycle
		byp_hit = s1_adv && (row_we || rel_grp) && (gid_s1 == group_id);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_v_q     <= 1'b0;
			group_map_q <= tlida_pkg::bit_mask('0);
			vld_q       <= '0;
		end else begin
			if (accept) v_s1 <= 1'b1;
			else if (s1_adv) v_s1 <= 1'b0;

			if (s1_adv) out_v_q <= 1'b1;
			else if (!rsp_stall) out_v_q <= 1'b0;

			if (s1_adv) begin
				group_map_q <= gm_nxt;
				if (rel_grp) vld_q[gid_s1] <= 1'b0;
				else if (row_we) vld_q[gid_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1  <= action;
			gid_s1     <= group_id;
			mid_s1     <= member_id;
			hit_s1     <= byp_hit;
			byp_row_s1 <= rel_grp ? '0 : row_nxt;
			rowv_s1    <= vld_q[group_id];
		end
		if (s1_adv) begin
			status_q  <= st_nxt;
			granted_q <= grant_nxt;
			is_set_q  <= set_nxt;
		end
	end

	assign rsp_valid  = out_v_q;
	assign status     = status_q;
	assign granted_id = granted_q;
	assign is_set     = is_set_q;

	a_grant_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != tlida_pkg::ST_OK) |-> (granted_id == '0))
		else $error("nonzero grant on a failed beat");

	a_set_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && is_set) |-> (status == tlida_pkg::ST_OK))
		else $error("query answer set on a failed beat");

	a_stall_backs_up: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && rsp_valid && rsp_stall) |-> req_stall)
		else $error("request taken while the work stage is blocked");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !req_stall) |=> rsp_valid)
		else $error("work stage advanced without a response");

endmodule

### sim/testbench.sv
module testbench;
	import tlida_pkg::*;

	localparam logic [2:0] ACT_RSVD_6 = 3'd6;
	localparam logic [2:0] ACT_RSVD_7 = 3'd7;
	localparam int RANDOM_BEATS = 1325;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		st_t  st;
		idx_t gnt;
		logic set;
	} reply_t;

	typedef struct packed {
		logic [2:0] act;
		idx_t       gid;
		idx_t       mid;
		logic       typed;
		reply_t     want;
	} step_t;

	// rows with typed = 0 take their expectation from the predictor
	localparam step_t DIRECTED [0:24] = '{
		'{ACT_QUERY_GRP, 6'd0,  6'd0,  1'b1, '{ST_OK,    6'd0, 1'b1}},
		'{ACT_QUERY_GRP, 6'd63, 6'd0,  1'b1, '{ST_OK,    6'd0, 1'b0}},
		'{ACT_ALLOC_GRP, 6'd0,  6'd0,  1'b1, '{ST_OK,    6'd1, 1'b0}},
		'{ACT_QUERY_GRP, 6'd1,  6'd0,  1'b1, '{ST_OK,    6'd0, 1'b1}},
		'{ACT_ALLOC_ID,  6'd5,  6'd0,  1'b1, '{ST_OK,    6'd0, 1'b0}},
		'{ACT_ALLOC_ID,  6'd5,  6'd63, 1'b1, '{ST_OK,    6'd1, 1'b0}},
		'{ACT_QUERY_ID,  6'd5,  6'd1,  1'b1, '{ST_OK,    6'd0, 1'b1}},
		'{ACT_QUERY_ID,  6'd5,  6'd63, 1'b1, '{ST_OK,    6'd0, 1'b0}},
		'{ACT_REL_ID,    6'd5,  6'd0,  1'b1, '{ST_OK,    6'd0, 1'b0}},
		'{ACT_ALLOC_ID,  6'd5,  6'd0,  1'b1, '{ST_OK,    6'd0, 1'b0}},
		'{ACT_REL_GRP,   6'd5,  6'd0,  1'b1, '{ST_OK,    6'd0, 1'b0}},
		'{ACT_QUERY_ID,  6'd5,  6'd1,  1'b1, '{ST_OK,    6'd0, 1'b0}},
		'{ACT_ALLOC_ID,  6'd63, 6'd0,  1'b1, '{ST_OK,    6'd0, 1'b0}},
		'{ACT_QUERY_ID,  6'd63, 6'd0,  1'b1, '{ST_OK,    6'd0, 1'b1}},
		'{ACT_REL_ID,    6'd63, 6'd63, 1'b1, '{ST_OK,    6'd0, 1'b0}},
		'{ACT_RSVD_6,    6'd63, 6'd63, 1'b1, '{ST_RANGE, 6'd0, 1'b0}},
		'{ACT_RSVD_7,    6'd0,  6'd0,  1'b1, '{ST_RANGE, 6'd0, 1'b0}},
		'{ACT_REL_GRP,   6'd0,  6'd0,  1'b1, '{ST_OK,    6'd0, 1'b0}},
		'{ACT_QUERY_GRP, 6'd0,  6'd0,  1'b1, '{ST_OK,    6'd0, 1'b0}},
		'{ACT_ALLOC_GRP, 6'd63, 6'd63, 1'b1, '{ST_OK,    6'd0, 1'b0}},
		'{ACT_ALLOC_GRP, 6'd0,  6'd0,  1'b1, '{ST_OK,    6'd2, 1'b0}},
		'{ACT_QUERY_ID,  6'd0,  6'd0,  1'b1, '{ST_OK,    6'd0, 1'b0}},
		'{ACT_REL_GRP,   6'd63, 6'd0,  1'b1, '{ST_OK,    6'd0, 1'b0}},
		'{ACT_QUERY_ID,  6'd63, 6'd0,  1'b1, '{ST_OK,    6'd0, 1'b0}},
		'{ACT_ALLOC_ID,  6'd63, 6'd0,  1'b0, '{ST_OK,    6'd0, 1'b0}}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	logic [2:0] action = '0;
	logic [5:0] group_id = '0;
	logic [5:0] member_id = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	logic [1:0] status;
	logic [5:0] granted_id;
	logic       is_set;

	row_t   grp_map;
	row_t   mem_rows [ROWS];
	reply_t replies_due [$];
	int     errors = 0;
	int     idle_cycles = 0;
	int     run_left = 0;
	bit     calm = 1'b0;

	two_level_id_bitmap_allocator_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.action     (action),
		.group_id   (group_id),
		.member_id  (member_id),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.granted_id (granted_id),
		.is_set     (is_set)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// index n sits at bit 63-n
	function automatic int first_clear(input row_t row, input int limit);
		for (int n = 0; n < limit; n++) begin
			if (!row[ROW_BITS-1-n]) return n;
		end
		return limit;
	endfunction

	function automatic reply_t apply_request(input logic [2:0] a, input idx_t g, input idx_t m);
		reply_t r;
		int     n;
		r = '0;
		r.st = ST_OK;
		if (a == ACT_ALLOC_GRP) begin
			n = first_clear(grp_map, NUM_GROUPS);
			if (n >= NUM_GROUPS) begin
				r.st = ST_FULL;
			end else begin
				grp_map[ROW_BITS-1-n] = 1'b1;
				r.gnt = idx_t'(n);
			end
		end else if (a > ACT_QUERY_ID) begin
			r.st = ST_RANGE;
		end else if (int'(g) >= NUM_GROUPS) begin
			r.st = ST_RANGE;
		end else if (a == ACT_ALLOC_ID) begin
			n = first_clear(mem_rows[g], NUM_MEMBERS);
			if (n >= NUM_MEMBERS) begin
				r.st = ST_FULL;
			end else begin
				mem_rows[g][ROW_BITS-1-n] = 1'b1;
				r.gnt = idx_t'(n);
			end
		end else if (a == ACT_REL_GRP) begin
			grp_map[ROW_BITS-1-int'(g)] = 1'b0;
			mem_rows[g] = '0;
		end else if (a == ACT_QUERY_GRP) begin
			r.set = grp_map[ROW_BITS-1-int'(g)];
		end else if (int'(m) >= NUM_MEMBERS) begin
			r.st = ST_RANGE;
		end else if (a == ACT_REL_ID) begin
			mem_rows[g][ROW_BITS-1-int'(m)] = 1'b0;
		end else begin
			r.set = mem_rows[g][ROW_BITS-1-int'(m)];
		end
		return r;
	endfunction

	// mostly back to back, a few long holes
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 2);
		if (r < 97) return $urandom_range(3, 8);
		return $urandom_range(20, 50);
	endfunction

	task automatic send_beat(input logic [2:0] a, input idx_t g, input idx_t m,
			input logic typed, input reply_t want);
		int     gap;
		reply_t r;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		action    <= a;
		group_id  <= g;
		member_id <= m;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		r = apply_request(a, g, m);
		replies_due.push_back(typed ? want : r);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		do @(posedge clk); while (replies_due.size() != 0);
	endtask

	task automatic send_free(input logic [2:0] a, input idx_t g);
		send_beat(a, g, idx_t'($urandom), 1'b0, '0);
	endtask

	always @(posedge clk) begin : rsp_side
		reply_t want;
		if (rsp_valid && !rsp_stall) begin
			if (replies_due.size() == 0) begin
				$display("%0t: unexpected reply beat, status %0d granted %0d set %0b",
					$time, status, granted_id, is_set);
				errors++;
			end else begin
				want = replies_due.pop_front();
				if (status !== want.st) begin
					$display("%0t: status expected %0d got %0d", $time, want.st, status);
					errors++;
				end
				if (granted_id !== want.gnt) begin
					$display("%0t: granted_id expected %0d got %0d",
						$time, want.gnt, granted_id);
					errors++;
				end
				if (is_set !== want.set) begin
					$display("%0t: is_set expected %0b got %0b", $time, want.set, is_set);
					errors++;
				end
			end
		end
		if (calm) begin
			rsp_stall <= 1'b0;
			run_left  <= 0;
		end else if (run_left > 0) begin
			run_left <= run_left - 1;
		end else if (rsp_stall) begin
			rsp_stall <= 1'b0;
			run_left  <= $urandom_range(0, 24);
		end else begin
			rsp_stall <= 1'b1;
			run_left  <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) :
				($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int   sent;
		int   sel;
		int   len;
		idx_t g;
		grp_map = '0;
		grp_map[ROW_BITS-1] = 1'b1;
		foreach (mem_rows[r]) mem_rows[r] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			send_beat(DIRECTED[i].act, DIRECTED[i].gid, DIRECTED[i].mid,
				DIRECTED[i].typed, DIRECTED[i].want);
		end
		wait_idle();

		sent = 0;
		while (sent < RANDOM_BEATS) begin
			calm = ($urandom_range(0, 4) == 0);
			sel  = $urandom_range(0, 99);
			if (sel < 25) begin
				// long enough runs to drain the group map
				len = $urandom_range(4, 70);
				repeat (len) send_free(ACT_ALLOC_GRP, idx_t'($urandom));
				send_free(ACT_QUERY_GRP, idx_t'($urandom));
				sent += len + 1;
			end else if (sel < 50) begin
				// favor a few groups so their member rows fill up
				g   = $urandom_range(0, 1) ? idx_t'($urandom_range(0, 3)) : idx_t'($urandom);
				len = $urandom_range(4, 70);
				repeat (len) send_free(ACT_ALLOC_ID, g);
				repeat (4) send_free(ACT_QUERY_ID, g);
				sent += len + 4;
			end else if (sel < 70) begin
				g   = $urandom_range(0, 1) ? idx_t'($urandom_range(0, 3)) : idx_t'($urandom);
				len = $urandom_range(1, 12);
				repeat (len) begin
					case ($urandom_range(0, 3))
						0:       send_free(ACT_REL_GRP, idx_t'($urandom));
						1:       send_free(ACT_QUERY_ID, g);
						default: send_free(ACT_REL_ID, g);
					endcase
				end
				sent += len;
			end else begin
				len = $urandom_range(1, 20);
				repeat (len) send_free(3'($urandom_range(0, 7)), idx_t'($urandom));
				sent += len;
			end
			if ($urandom_range(0, 9) == 0) wait_idle();
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && replies_due.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### sim.f
hdl/tlida_pkg.sv
hdl/tlida_ram.sv
hdl/two_level_id_bitmap_allocator_top.sv
sim/testbench.sv
